[hdl/bcd_clock_with_autorepeat_set_macros.svh]
// assertion macros for the bcd clock with auto-repeat set buttons
// used by the top level; no other dependencies

`ifndef BCD_CLOCK_WITH_AUTOREPEAT_SET_MACROS_SVH
`define BCD_CLOCK_WITH_AUTOREPEAT_SET_MACROS_SVH

// condition holds at every clock edge outside reset
`define BCD_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequence holds in the cycle after the antecedent
`define BCD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/bcd_clk_pkg.sv]
// types, codes and digit update functions of the bcd clock
// no dependencies; imported by the top level
`timescale 1ns / 1ps
`default_nettype none

package bcd_clk_pkg;

  // event codes carried in the operation field
  typedef enum logic [1:0] {
    OP_SECOND = 2'd0,
    OP_SCAN   = 2'd1,
    OP_PRESS  = 2'd2
  } op_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_INITIAL_DELAY = 2'd0,
    CFG_REPEAT_AT     = 2'd1,
    CFG_REPEAT_RELOAD = 2'd2
  } cfg_idx_t;

  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned TickWidth     = 7;

  localparam logic [TickWidth-1:0] InitialDelayReset = 7'd20;
  localparam logic [TickWidth-1:0] RepeatAtReset     = 7'd100;
  localparam logic [TickWidth-1:0] RepeatReloadReset = 7'd21;

  typedef struct packed {
    logic [1:0] operation;
    logic       minute_button;
    logic       hour_button;
  } in_item_t;

  typedef struct packed {
    logic [1:0] hour_tens;
    logic [3:0] hour_ones;
    logic [2:0] minute_tens;
    logic [3:0] minute_ones;
    logic [5:0] seconds;
    logic       colon_on;
    logic       scanning;
    logic [6:0] seg_hour_tens;
    logic [6:0] seg_hour_ones;
    logic [6:0] seg_minute_tens;
    logic [6:0] seg_minute_ones;
  } out_item_t;

  // time of day as bcd digits plus seconds
  typedef struct packed {
    logic [1:0] hour_tens;
    logic [3:0] hour_ones;
    logic [2:0] minute_tens;
    logic [3:0] minute_ones;
    logic [5:0] seconds;
  } clk_time_t;

  // segments a..g in bits 0..6, codes above nine blank
  function automatic logic [6:0] seg_decode(input logic [3:0] digit);
    logic [6:0] seg;
    unique case (digit)
      4'd0:    seg = 7'h3F;
      4'd1:    seg = 7'h06;
      4'd2:    seg = 7'h5B;
      4'd3:    seg = 7'h4F;
      4'd4:    seg = 7'h66;
      4'd5:    seg = 7'h6D;
      4'd6:    seg = 7'h7D;
      4'd7:    seg = 7'h07;
      4'd8:    seg = 7'h7F;
      4'd9:    seg = 7'h6F;
      default: seg = 7'h00;
    endcase
    return seg;
  endfunction

  function automatic clk_time_t wrap_hours(input clk_time_t t_in);
    clk_time_t t;
    t = t_in;
    if (t.hour_ones >= 4'd10) begin
      t.hour_ones = 4'd0;
      t.hour_tens = t.hour_tens + 2'd1;
    end
    if (t.hour_tens == 2'd2 && t.hour_ones == 4'd4) begin
      t.hour_tens = 2'd0;
      t.hour_ones = 4'd0;
    end
    return t;
  endfunction

  // set-button minute step: clears seconds, no carry into hours
  function automatic clk_time_t step_minutes(input clk_time_t t_in);
    clk_time_t t;
    t = t_in;
    t.minute_ones = t.minute_ones + 4'd1;
    t.seconds     = 6'd0;
    if (t.minute_ones >= 4'd10) begin
      t.minute_ones = 4'd0;
      t.minute_tens = t.minute_tens + 3'd1;
    end
    if (t.minute_tens >= 3'd6) begin
      t.minute_ones = 4'd0;
      t.minute_tens = 3'd0;
    end
    return t;
  endfunction

  function automatic clk_time_t step_hours(input clk_time_t t_in);
    clk_time_t t;
    t = t_in;
    t.hour_ones = t.hour_ones + 4'd1;
    return wrap_hours(t);
  endfunction

  // one step of the held button, minute button first
  function automatic clk_time_t step_button(input clk_time_t t_in, input logic minute_held);
    clk_time_t t;
    if (minute_held) begin
      t = step_minutes(t_in);
    end else begin
      t = step_hours(t_in);
    end
    return t;
  endfunction

  // one second of running time with full carry chain
  function automatic clk_time_t second_tick(input clk_time_t t_in);
    clk_time_t t;
    t = t_in;
    t.seconds = t.seconds + 6'd1;
    if (t.seconds >= 6'd60) begin
      t.seconds     = 6'd0;
      t.minute_ones = t.minute_ones + 4'd1;
    end
    if (t.minute_ones >= 4'd10) begin
      t.minute_ones = 4'd0;
      t.minute_tens = t.minute_tens + 3'd1;
    end
    if (t.minute_tens >= 3'd6) begin
      t.minute_tens = 3'd0;
      t.hour_ones   = t.hour_ones + 4'd1;
    end
    return wrap_hours(t);
  endfunction

endpackage

`default_nettype wire

[hdl/bcd_clock_with_autorepeat_set.sv]
// top level of the 24-hour bcd clock with auto-repeat set buttons
// depends on bcd_clk_pkg and bcd_clock_with_autorepeat_set_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "bcd_clock_with_autorepeat_set_macros.svh"

// 24-hour bcd clock driven by events. every input item is one event
// (second tick, button scan tick or button press edge) and gives exactly
// one result item showing the time, colon, scan flag and seven-segment
// patterns after that event. the clock state and the result register are
// updated in the cycle the item is accepted, so an item can be taken every
// cycle and its result appears in the next cycle; the single output register
// decides the rate, and in_ready only drops while a result sits unread
// with out_ready low. a press edge starts the scan and clears the scan
// counter; scan ticks with a button held step the minutes (which clears
// the seconds, no carry into the hours) or the hours, first at
// initial_delay_ticks and then at repeat_at_ticks, after which the counter
// reloads from repeat_reload. the minute button wins when both are held.
// configuration writes are always taken (cfg_ready is tied high); an
// index past the last register is dropped.
module bcd_clock_with_autorepeat_set (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  input  wire logic                                     in_valid,
  output logic                                          in_ready,
  input  wire bcd_clk_pkg::in_item_t                    in_item,
  output logic                                          out_valid,
  input  wire logic                                     out_ready,
  output bcd_clk_pkg::out_item_t                        out_item,
  input  wire logic                                     cfg_valid,
  output logic                                          cfg_ready,
  input  wire logic [bcd_clk_pkg::CfgIndexWidth-1:0]    cfg_index,
  input  wire logic [bcd_clk_pkg::TickWidth-1:0]        cfg_data
);
  import bcd_clk_pkg::*;

  // configuration registers
  logic [TickWidth-1:0] initial_delay_ticks;
  logic [TickWidth-1:0] repeat_at_ticks;
  logic [TickWidth-1:0] repeat_reload;

  // clock state
  clk_time_t            tm;
  clk_time_t            tm_next;
  logic                 colon_state;      // 1 means colon off
  logic                 colon_state_next;
  logic [TickWidth-1:0] scan_count;
  logic [TickWidth-1:0] scan_count_next;
  logic                 scan_active;
  logic                 scan_active_next;

  logic      in_fire;
  logic      out_fire;
  clk_time_t tm_step;
  logic      held;

  assign cfg_ready = 1'b1;
  assign out_fire  = out_valid && out_ready;
  // output register frees up in the same cycle it is read
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign held      = in_item.minute_button || in_item.hour_button;

  // scan tick step logic: both compares use the count before reload,
  // so equal thresholds give two steps in one tick
  always_comb begin
    tm_step = tm;
    if (scan_count == initial_delay_ticks) begin
      tm_step = step_button(tm_step, in_item.minute_button);
    end
    if (scan_count == repeat_at_ticks) begin
      tm_step = step_button(tm_step, in_item.minute_button);
    end
  end

  // next state for the accepted event
  always_comb begin
    tm_next          = tm;
    colon_state_next = colon_state;
    scan_count_next  = scan_count;
    scan_active_next = scan_active;
    unique case (in_item.operation)
      OP_SECOND: begin
        tm_next          = second_tick(tm);
        colon_state_next = !colon_state;
      end
      OP_SCAN: begin
        // ignored while the scan is stopped
        if (scan_active) begin
          if (held) begin
            tm_next = tm_step;
            if (scan_count == repeat_at_ticks) begin
              scan_count_next = repeat_reload + 7'd1;
            end else begin
              scan_count_next = scan_count + 7'd1;
            end
          end else begin
            // count still advances on the tick that stops the scan
            scan_active_next = 1'b0;
            scan_count_next  = scan_count + 7'd1;
          end
        end
      end
      OP_PRESS: begin
        scan_active_next = 1'b1;
        scan_count_next  = '0;
      end
      default: begin
        // unused code, no change
      end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      initial_delay_ticks <= InitialDelayReset;
      repeat_at_ticks     <= RepeatAtReset;
      repeat_reload       <= RepeatReloadReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_INITIAL_DELAY: initial_delay_ticks <= cfg_data;
        CFG_REPEAT_AT:     repeat_at_ticks     <= cfg_data;
        CFG_REPEAT_RELOAD: repeat_reload       <= cfg_data;
        default: begin
          // no register at this index
        end
      endcase
    end
  end

  // clock state and result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      tm          <= '0;
      colon_state <= 1'b1;
      scan_count  <= '0;
      scan_active <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (in_fire) begin
        tm          <= tm_next;
        colon_state <= colon_state_next;
        scan_count  <= scan_count_next;
        scan_active <= scan_active_next;
        out_valid   <= 1'b1;
      end else if (out_fire) begin
        out_valid   <= 1'b0;
      end
    end
  end

  // result payload, loaded with the state after the event
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_item.hour_tens       <= tm_next.hour_tens;
      out_item.hour_ones       <= tm_next.hour_ones;
      out_item.minute_tens     <= tm_next.minute_tens;
      out_item.minute_ones     <= tm_next.minute_ones;
      out_item.seconds         <= tm_next.seconds;
      out_item.colon_on        <= !colon_state_next;
      out_item.scanning        <= scan_active_next;
      out_item.seg_hour_tens   <= seg_decode({2'b00, tm_next.hour_tens});
      out_item.seg_hour_ones   <= seg_decode(tm_next.hour_ones);
      out_item.seg_minute_tens <= seg_decode({1'b0, tm_next.minute_tens});
      out_item.seg_minute_ones <= seg_decode(tm_next.minute_ones);
    end
  end

  // time never leaves 00:00:00 .. 23:59:59
  `BCD_ASSERT_ALWAYS(a_time_range, clk, rst, (tm.hour_tens < 2'd2 || (tm.hour_tens == 2'd2 && tm.hour_ones < 4'd4)) && tm.hour_ones < 4'd10 && tm.minute_tens < 3'd6 && tm.minute_ones < 4'd10 && tm.seconds < 6'd60, "time out of range")
  // a press edge starts the scan from zero
  `BCD_ASSERT_NEXT(a_press_starts_scan, clk, rst, in_fire && in_item.operation == OP_PRESS, scan_active && scan_count == 7'd0, "press edge did not start scan")
  // scan ticks while stopped leave the time alone
  `BCD_ASSERT_NEXT(a_idle_scan_hold, clk, rst, in_fire && in_item.operation == OP_SCAN && !scan_active, $stable(tm) && !scan_active, "stopped scan changed state")
  // each accepted item shows up with the state it produced
  `BCD_ASSERT_NEXT(a_result_tracks_state, clk, rst, in_fire, out_valid && out_item.seconds == tm.seconds && out_item.scanning == scan_active && out_item.colon_on == !colon_state, "result does not match state")

endmodule

`default_nettype wire

[tb/sv/bcd_clock_with_autorepeat_set_test.sv]
`timescale 1ns / 1ps
// self-checking bench of the 24-hour bcd clock with auto-repeat set buttons
// drives event items, predicts each display item in-bench and compares by field
// depends on bcd_clk_pkg and the bcd_clock_with_autorepeat_set top level

module bcd_clock_with_autorepeat_set_test;
  import bcd_clk_pkg::*;

  // operation code 3 has no name in the package, the clock ignores it
  localparam op_t OP_UNUSED = op_t'(2'd3);
  // register index past the last register, writes to it are dropped
  localparam logic [CfgIndexWidth-1:0] CFG_UNUSED = 2'd3;

  localparam int unsigned STALL_LIMIT  = 2000;  // cycles with no handshake at all
  localparam int unsigned SETTLE_TICKS = 4;

  // segments a..g in bits 0..6, codes above nine are dark
  localparam logic [6:0] DIGIT_FONT [16] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

  // clock, reset and block ports; the driven ones are known from time zero
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIndexWidth-1:0] cfg_index = '0;
  logic [TickWidth-1:0] cfg_data = '0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  bcd_clock_with_autorepeat_set i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // in-bench copy of the clock: time digits, colon, scan timer and settings
  // ---------------------------------------------------------------------------
  logic [1:0] hr_tens = '0;
  logic [3:0] hr_ones = '0;
  logic [2:0] mn_tens = '0;
  logic [3:0] mn_ones = '0;
  logic [5:0] sec_count = '0;
  logic       colon_dark = 1'b1;  // colon starts off after reset
  logic [6:0] scan_ticks = '0;
  logic       scan_on = 1'b0;

  logic [TickWidth-1:0] first_step_at  = InitialDelayReset;
  logic [TickWidth-1:0] repeat_step_at = RepeatAtReset;
  logic [TickWidth-1:0] reload_to      = RepeatReloadReset;

  // display items still owed by the block, oldest first
  out_item_t expected_displays [$];

  int unsigned error_count = 0;
  int unsigned effective_items = 0;  // accepted items that changed the clock
  int unsigned quiet_cycles = 0;
  int unsigned ready_hold_request = 0;
  bit sender_idles = 1'b1;
  bit receiver_idles = 1'b1;

  // hours roll 9 -> 10 and 23 -> 00
  function automatic void carry_hours();
    if (hr_ones >= 4'd10) begin
      hr_ones = 4'd0;
      hr_tens = hr_tens + 2'd1;
    end
    if (hr_tens == 2'd2 && hr_ones == 4'd4) begin
      hr_tens = 2'd0;
      hr_ones = 4'd0;
    end
  endfunction

  // minute button step: seconds cleared, 59 -> 00 without touching the hours
  function automatic void set_minute_step();
    mn_ones = mn_ones + 4'd1;
    sec_count = 6'd0;
    if (mn_ones >= 4'd10) begin
      mn_ones = 4'd0;
      mn_tens = mn_tens + 3'd1;
    end
    if (mn_tens >= 3'd6) begin
      mn_ones = 4'd0;
      mn_tens = 3'd0;
    end
  endfunction

  function automatic void set_hour_step();
    hr_ones = hr_ones + 4'd1;
    carry_hours();
  endfunction

  // running time: seconds carry into minutes, minutes into hours
  function automatic void tick_second();
    sec_count = sec_count + 6'd1;
    colon_dark = ~colon_dark;
    if (sec_count >= 6'd60) begin
      sec_count = 6'd0;
      mn_ones = mn_ones + 4'd1;
    end
    if (mn_ones >= 4'd10) begin
      mn_ones = 4'd0;
      mn_tens = mn_tens + 3'd1;
    end
    if (mn_tens >= 3'd6) begin
      mn_tens = 3'd0;
      hr_ones = hr_ones + 4'd1;
    end
    carry_hours();
  endfunction

  // advances the model by one event, returns 0 when the clock ignores it
  function automatic bit apply_event(input in_item_t ev);
    bit changed;
    changed = 1'b1;
    case (op_t'(ev.operation))
      OP_SECOND: tick_second();
      OP_SCAN: begin
        if (!scan_on) begin
          changed = 1'b0;
        end else begin
          if (ev.minute_button || ev.hour_button) begin
            // first-step test, then repeat test on the same count
            if (scan_ticks == first_step_at) begin
              if (ev.minute_button) set_minute_step();
              else set_hour_step();
            end
            if (scan_ticks == repeat_step_at) begin
              if (ev.minute_button) set_minute_step();
              else set_hour_step();
              scan_ticks = reload_to;
            end
          end else begin
            scan_on = 1'b0;
          end
          // counter moves on even on the tick that stops the scan
          scan_ticks = scan_ticks + 7'd1;
        end
      end
      OP_PRESS: begin
        scan_on = 1'b1;
        scan_ticks = 7'd0;
      end
      default: changed = 1'b0;
    endcase
    return changed;
  endfunction

  function automatic out_item_t shown_display();
    out_item_t d;
    d.hour_tens       = hr_tens;
    d.hour_ones       = hr_ones;
    d.minute_tens     = mn_tens;
    d.minute_ones     = mn_ones;
    d.seconds         = sec_count;
    d.colon_on        = ~colon_dark;
    d.scanning        = scan_on;
    d.seg_hour_tens   = DIGIT_FONT[{2'b00, hr_tens}];
    d.seg_hour_ones   = DIGIT_FONT[hr_ones];
    d.seg_minute_tens = DIGIT_FONT[{1'b0, mn_tens}];
    d.seg_minute_ones = DIGIT_FONT[mn_ones];
    return d;
  endfunction

  function automatic in_item_t pack_event(input op_t op, input logic minute, input logic hour);
    in_item_t ev;
    ev.operation     = op;
    ev.minute_button = minute;
    ev.hour_button   = hour;
    return ev;
  endfunction

  // ---------------------------------------------------------------------------
  // error reporting and result checking
  // ---------------------------------------------------------------------------
  task automatic flag_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want) flag_error($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  // every accepted display item is matched against the oldest prediction
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_displays.size() == 0) begin
        flag_error("display item with no event waiting for it");
      end else begin
        want = expected_displays.pop_front();
        check_field("hour_tens", out_item.hour_tens, want.hour_tens);
        check_field("hour_ones", out_item.hour_ones, want.hour_ones);
        check_field("minute_tens", out_item.minute_tens, want.minute_tens);
        check_field("minute_ones", out_item.minute_ones, want.minute_ones);
        check_field("seconds", out_item.seconds, want.seconds);
        check_field("colon_on", out_item.colon_on, want.colon_on);
        check_field("scanning", out_item.scanning, want.scanning);
        check_field("seg_hour_tens", out_item.seg_hour_tens, want.seg_hour_tens);
        check_field("seg_hour_ones", out_item.seg_hour_ones, want.seg_hour_ones);
        check_field("seg_minute_tens", out_item.seg_minute_tens, want.seg_minute_tens);
        check_field("seg_minute_ones", out_item.seg_minute_ones, want.seg_minute_ones);
      end
    end
  end

  // run ends if no handshake of any kind happens for too long
  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // display side: random stall bursts, plus a long hold-off on request
  initial begin : receiver
    int unsigned stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (ready_hold_request != 0) begin
        stall = ready_hold_request;
        ready_hold_request = 0;
      end else if (stall == 0 && receiver_idles && $urandom_range(0, 9) == 0) begin
        stall = $urandom_range(1, 19);
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // shared drivers
  // ---------------------------------------------------------------------------
  // offers one event item, returns at the edge where it is taken; valid stays
  // high so a following item goes out back to back
  task automatic send_event(input in_item_t ev);
    int unsigned gap;
    if (sender_idles && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= ev;
    do @(posedge clk); while (!in_ready);
    if (apply_event(ev)) effective_items++;
    expected_displays.push_back(shown_display());
  endtask

  // stops offering items until every owed display item has come out
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_displays.size() != 0);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic write_register(input logic [CfgIndexWidth-1:0] idx,
                                input logic [TickWidth-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_INITIAL_DELAY: first_step_at = value;
      CFG_REPEAT_AT:     repeat_step_at = value;
      CFG_REPEAT_RELOAD: reload_to = value;
      default: ;  // unused index, nothing changes
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // settings only change with the clock idle and nothing owed
  task automatic load_settings(input logic [TickWidth-1:0] first,
                               input logic [TickWidth-1:0] again,
                               input logic [TickWidth-1:0] reload);
    wait_results_drained();
    write_register(CFG_INITIAL_DELAY, first);
    write_register(CFG_REPEAT_AT, again);
    write_register(CFG_REPEAT_RELOAD, reload);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // reset display, every operation code, button combinations, scan start,
  // stop and restart, ignored ticks while stopped, the unused code
  task automatic test_directed_events();
    in_item_t script [$];
    script = '{
      pack_event(OP_UNUSED, 1'b1, 1'b1),  // ignored, shows the reset display
      pack_event(OP_SCAN,   1'b1, 1'b0),  // scan stopped, ignored
      pack_event(OP_SECOND, 1'b0, 1'b0),  // colon lights
      pack_event(OP_SECOND, 1'b1, 1'b1),  // buttons mean nothing here
      pack_event(OP_PRESS,  1'b0, 1'b0),  // scan starts
      pack_event(OP_SCAN,   1'b1, 1'b1),  // both held, count too low to step
      pack_event(OP_SCAN,   1'b0, 1'b1),
      pack_event(OP_UNUSED, 1'b0, 1'b0),  // ignored while scanning
      pack_event(OP_SCAN,   1'b0, 1'b0),  // released, scan stops
      pack_event(OP_SCAN,   1'b0, 1'b1),  // ignored again
      pack_event(OP_PRESS,  1'b1, 1'b1),
      pack_event(OP_PRESS,  1'b1, 1'b0),  // press while scanning restarts
      pack_event(OP_SCAN,   1'b1, 1'b0),
      pack_event(OP_SCAN,   1'b0, 1'b0),
      pack_event(OP_SECOND, 1'b0, 1'b1)
    };
    foreach (script[i]) send_event(script[i]);
  endtask

  // display side holds off while events keep coming, so the input stalls;
  // then the sender waits for every display item
  task automatic test_input_stall();
    sender_idles = 1'b0;
    ready_hold_request = 80;
    repeat (30) begin
      send_event(pack_event(op_t'($urandom_range(0, 2)), 1'($urandom), 1'($urandom)));
    end
    sender_idles = 1'b1;
    wait_results_drained();
  endtask

  // set 23:59 with the buttons, then let the seconds run over midnight
  task automatic test_midnight_rollover();
    load_settings(7'd1, 7'd2, 7'd0);
    send_event(pack_event(OP_PRESS, 1'($urandom), 1'($urandom)));
    while (!(hr_tens == 2'd2 && hr_ones == 4'd3)) begin
      send_event(pack_event(OP_SCAN, 1'b0, 1'b1));
    end
    // both held on some ticks, the minute button wins
    while (!(mn_tens == 3'd5 && mn_ones == 4'd9)) begin
      send_event(pack_event(OP_SCAN, 1'b1, 1'($urandom)));
    end
    send_event(pack_event(OP_SCAN, 1'b0, 1'b0));
    while (hr_tens == 2'd2) begin
      send_event(pack_event(OP_SECOND, 1'($urandom), 1'($urandom)));
    end
  endtask

  // mostly press-and-hold sessions long enough to reach the first and repeat
  // steps, with runs of second ticks and some noise in between
  task automatic test_autorepeat_sessions(input int unsigned until_count);
    int unsigned kind;
    int unsigned span;
    int unsigned n;
    int unsigned k;
    logic [1:0] held;  // {minute, hour}
    while (effective_items < until_count) begin
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        held = 2'($urandom_range(1, 3));
        send_event(pack_event(OP_PRESS, 1'($urandom), 1'($urandom)));
        case ($urandom_range(0, 9))
          0:       span = 140 + $urandom_range(0, 20);  // long enough to wrap the counter
          1, 2, 3: span = repeat_step_at + $urandom_range(1, 30);
          default: span = first_step_at + $urandom_range(1, 8);
        endcase
        k = 0;
        while (k < span && scan_on) begin
          if ($urandom_range(0, 14) == 0) begin
            send_event(pack_event(OP_SECOND, 1'($urandom), 1'($urandom)));
          end
          // occasionally change the held buttons, release stops the scan
          if ($urandom_range(0, 24) == 0) held = 2'($urandom_range(0, 3));
          send_event(pack_event(OP_SCAN, held[1], held[0]));
          k++;
        end
        if (scan_on && $urandom_range(0, 3) != 0) begin
          send_event(pack_event(OP_SCAN, 1'b0, 1'b0));
        end
      end else if (kind < 75) begin
        n = $urandom_range(1, 70);
        repeat (n) send_event(pack_event(OP_SECOND, 1'($urandom), 1'($urandom)));
      end else begin
        n = $urandom_range(1, 10);
        repeat (n) begin
          send_event(pack_event(op_t'($urandom_range(0, 3)), 1'($urandom), 1'($urandom)));
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence of the run
  // ---------------------------------------------------------------------------
  initial begin : run
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_directed_events();
    test_input_stall();
    test_midnight_rollover();

    // settings sweep: reset values, both extremes, then random ones
    load_settings(InitialDelayReset, RepeatAtReset, RepeatReloadReset);
    test_autorepeat_sessions(300);
    load_settings(7'd126, 7'd127, 7'd126);
    test_autorepeat_sessions(450);
    load_settings(7'd1, 7'd127, 7'd0);
    test_autorepeat_sessions(530);
    load_settings(7'd126, 7'd2, 7'd126);
    test_autorepeat_sessions(580);
    load_settings(7'($urandom_range(1, 126)), 7'($urandom_range(2, 127)),
                  7'($urandom_range(0, 126)));
    write_register(CFG_UNUSED, 7'($urandom_range(0, 127)));  // must be dropped
    test_autorepeat_sessions(660);
    load_settings(7'($urandom_range(1, 126)), 7'($urandom_range(2, 127)),
                  7'($urandom_range(0, 126)));
    test_autorepeat_sessions(740);
    load_settings(7'($urandom_range(1, 40)), 7'($urandom_range(2, 40)),
                  7'($urandom_range(0, 40)));
    test_autorepeat_sessions(810);

    // last stretch at full rate on both sides
    sender_idles = 1'b0;
    receiver_idles = 1'b0;
    load_settings(7'd1, 7'd2, 7'd0);
    test_autorepeat_sessions(950);

    wait_results_drained();
    if (expected_displays.size() != 0) flag_error("display items never arrived");
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/bcd_clk_pkg.sv
hdl/bcd_clock_with_autorepeat_set.sv
tb/sv/bcd_clock_with_autorepeat_set_test.sv
